// ----- design/hdap_pkg.sv -----
// Shared types, codes and constants of the HTTP DNS answer parser.
package hdap_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [15:0] MAX_ANSWERS_RST = 16'd16;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] LEN_V4   = 8'd4;
  localparam logic [7:0] LEN_V6   = 8'd16;

  typedef enum logic [4:0] {
    ST_LIT, ST_D1, ST_D2, ST_D3, ST_SP, ST_RSN, ST_RSN_CR,
    ST_HDR, ST_HDR_CR, ST_HDR_NL, ST_HDR_CR2, ST_DNS,
    ST_QSTART, ST_QNAME, ST_QSKIP, ST_TTL0, ST_TTL,
    ST_LEN_HI, ST_LEN_LO, ST_ADDR4, ST_ADDR6, ST_GAP
  } pstate_t;

  typedef enum logic [1:0] {
    HALT_RUN = 2'd0,
    HALT_OK  = 2'd1,
    HALT_ERR = 2'd2
  } halt_t;

  typedef enum logic [1:0] {
    K_CHR  = 2'd0,
    K_ADDR = 2'd1,
    K_OK   = 2'd2,
    K_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_FORMAT = 3'd1,
    ERR_COUNT  = 3'd2,
    ERR_EXCESS = 3'd3,
    ERR_TRUNC  = 3'd4
  } err_t;

  // Results of one item: up to three slots, shared fields captured once
  typedef struct packed {
    logic [1:0]        n;
    kind_t [2:0]       kind;
    logic [2:0][7:0]   data;
    err_t              err;
    logic [3:0]        idx;
    logic              v6;
    logic [15:0]       rec;
    logic [31:0]       ttl;
    logic [9:0]        status;
    logic [15:0]       v4_cnt;
    logic [15:0]       v6_cnt;
  } bundle_t;

  // Characters of the status line prefix "HTTP/1.1 "
  function automatic logic [7:0] lit_char(input logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0: ch = 8'h48;
      4'd1: ch = 8'h54;
      4'd2: ch = 8'h54;
      4'd3: ch = 8'h50;
      4'd4: ch = 8'h2F;
      4'd5: ch = 8'h31;
      4'd6: ch = 8'h2E;
      4'd7: ch = 8'h31;
      4'd8: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/hdap_front.sv -----
// Front end: parses a byte per cycle when item_take is high into each item's bundle.
module hdap_front #(
  parameter int COUNT_WIDTH = hdap_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             item_take,
  input  logic [7:0]       data_byte,
  input  logic             eom,
  output logic             push,
  output hdap_pkg::bundle_t bundle
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  hdap_pkg::pstate_t st_r, st_nxt;
  hdap_pkg::halt_t   halt_r, halt_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [9:0]  status_r, status_nxt;
  logic [15:0] total_r, total_nxt;
  logic [31:0] ttl_r, ttl_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [COUNT_WIDTH-1:0] v4_r, v4_nxt, v6_r, v6_nxt;
  logic [15:0] maxa_r;

  logic fail, e_cr, e_chr, e_addr, e_ok;
  hdap_pkg::err_t fail_code;
  logic [COUNT_WIDTH-1:0] done;
  logic [4:0] pos5;
  logic [3:0] digit;
  logic [1:0] n;
  hdap_pkg::kind_t [2:0] sk;
  logic [2:0][7:0] sb;
  hdap_pkg::err_t err;
  logic [15:0] rec;
  logic is6;

  // Next state of the parser
  always_comb begin
    st_nxt = st_r; halt_nxt = halt_r; cnt_nxt = cnt_r; status_nxt = status_r;
    total_nxt = total_r; ttl_nxt = ttl_r; pos_nxt = pos_r; v4_nxt = v4_r; v6_nxt = v6_r;
    fail = 1'b0; fail_code = hdap_pkg::ERR_FORMAT;
    e_cr = 1'b0; e_chr = 1'b0; e_addr = 1'b0; e_ok = 1'b0;
    is6 = (st_r == hdap_pkg::ST_ADDR6);
    done = is6 ? v6_r : v4_r;
    pos5 = {1'b0, pos_r} + 5'd1;
    digit = 4'(data_byte - hdap_pkg::CH_ZERO);
    rec = 16'(done);
    if (halt_r == hdap_pkg::HALT_RUN) begin
      case (st_r)
        hdap_pkg::ST_LIT: begin
          if (data_byte == hdap_pkg::lit_char(cnt_r)) begin
            if (cnt_r == 4'd8) begin
              st_nxt = hdap_pkg::ST_D1; cnt_nxt = 4'd0;
            end else cnt_nxt = cnt_r + 4'd1;
          end else fail = 1'b1;
        end
        hdap_pkg::ST_D1: begin
          if (data_byte >= hdap_pkg::CH_ONE && data_byte <= hdap_pkg::CH_FIVE) begin
            status_nxt = 10'(digit) * 10'd100; st_nxt = hdap_pkg::ST_D2;
          end else fail = 1'b1;
        end
        hdap_pkg::ST_D2: begin
          if (data_byte >= hdap_pkg::CH_ZERO && data_byte <= hdap_pkg::CH_NINE) begin
            status_nxt = status_r + 10'(digit) * 10'd10; st_nxt = hdap_pkg::ST_D3;
          end else fail = 1'b1;
        end
        hdap_pkg::ST_D3: begin
          if (data_byte >= hdap_pkg::CH_ZERO && data_byte <= hdap_pkg::CH_NINE) begin
            status_nxt = status_r + 10'(digit); st_nxt = hdap_pkg::ST_SP;
          end else fail = 1'b1;
        end
        hdap_pkg::ST_SP: begin
          if (data_byte == hdap_pkg::CH_SPACE) st_nxt = hdap_pkg::ST_RSN;
          else fail = 1'b1;
        end
        hdap_pkg::ST_RSN: begin
          if (data_byte == hdap_pkg::CH_CR) st_nxt = hdap_pkg::ST_RSN_CR;
          else if (data_byte == 8'd0) fail = 1'b1;
          else e_chr = 1'b1;
        end
        hdap_pkg::ST_RSN_CR: begin
          if (data_byte == hdap_pkg::CH_LF) st_nxt = hdap_pkg::ST_HDR;
          else if (data_byte == 8'd0) fail = 1'b1;
          else begin
            e_cr = 1'b1; e_chr = 1'b1; st_nxt = hdap_pkg::ST_RSN;
          end
        end
        hdap_pkg::ST_HDR, hdap_pkg::ST_HDR_CR, hdap_pkg::ST_HDR_NL,
        hdap_pkg::ST_HDR_CR2: begin
          if (data_byte == 8'd0) fail = 1'b1;
          else if (data_byte == hdap_pkg::CH_CR && st_r == hdap_pkg::ST_HDR)
            st_nxt = hdap_pkg::ST_HDR_CR;
          else if (data_byte == hdap_pkg::CH_CR && st_r == hdap_pkg::ST_HDR_NL)
            st_nxt = hdap_pkg::ST_HDR_CR2;
          else if (data_byte == hdap_pkg::CH_LF && st_r == hdap_pkg::ST_HDR_CR)
            st_nxt = hdap_pkg::ST_HDR_NL;
          else if (data_byte == hdap_pkg::CH_LF && st_r == hdap_pkg::ST_HDR_CR2) begin
            st_nxt = hdap_pkg::ST_DNS; cnt_nxt = 4'd0;
          end else st_nxt = hdap_pkg::ST_HDR;
        end
        hdap_pkg::ST_DNS: begin
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd11) begin
            st_nxt = hdap_pkg::ST_QSTART; cnt_nxt = 4'd0;
          end
          if (cnt_r == 4'd6) total_nxt = {data_byte, 8'h00};
          if (cnt_r == 4'd7) begin
            total_nxt = {total_r[15:8], data_byte};
            if (total_nxt > maxa_r) begin
              fail = 1'b1; fail_code = hdap_pkg::ERR_COUNT;
            end else if (total_nxt == 16'd0) begin
              e_ok = 1'b1; halt_nxt = hdap_pkg::HALT_OK;
            end
          end
        end
        hdap_pkg::ST_QSTART: begin
          if (data_byte == 8'd0) begin
            st_nxt = hdap_pkg::ST_QSKIP; cnt_nxt = 4'd0;
          end else st_nxt = hdap_pkg::ST_QNAME;
        end
        hdap_pkg::ST_QNAME: begin
          if (data_byte == 8'd0) st_nxt = hdap_pkg::ST_QSTART;
        end
        // Question tail and fixed record fields before the TTL
        hdap_pkg::ST_QSKIP: begin
          if (cnt_r == 4'd8) st_nxt = hdap_pkg::ST_TTL0;
          else cnt_nxt = cnt_r + 4'd1;
        end
        hdap_pkg::ST_TTL0: begin
          ttl_nxt = {24'd0, data_byte}; st_nxt = hdap_pkg::ST_TTL; cnt_nxt = 4'd0;
        end
        hdap_pkg::ST_TTL: begin
          ttl_nxt = {ttl_r[23:0], data_byte};
          if (cnt_r == 4'd2) st_nxt = hdap_pkg::ST_LEN_HI;
          else cnt_nxt = cnt_r + 4'd1;
        end
        hdap_pkg::ST_LEN_HI: begin
          if (data_byte == 8'd0) st_nxt = hdap_pkg::ST_LEN_LO;
          else fail = 1'b1;
        end
        hdap_pkg::ST_LEN_LO: begin
          if (data_byte == hdap_pkg::LEN_V4) st_nxt = hdap_pkg::ST_ADDR4;
          else if (data_byte == hdap_pkg::LEN_V6) st_nxt = hdap_pkg::ST_ADDR6;
          else fail = 1'b1;
        end
        hdap_pkg::ST_ADDR4, hdap_pkg::ST_ADDR6: begin
          if (16'(done) >= total_r) begin
            fail = 1'b1; fail_code = hdap_pkg::ERR_EXCESS;
          end else begin
            e_addr = 1'b1;
            if (pos5 >= (is6 ? 5'd16 : 5'd4)) begin
              pos_nxt = 4'd0; st_nxt = hdap_pkg::ST_GAP;
              if (is6) begin
                if (v6_r != CNT_MAX) v6_nxt = v6_r + 1'b1;
              end else begin
                if (v4_r != CNT_MAX) v4_nxt = v4_r + 1'b1;
              end
            end else pos_nxt = pos5[3:0];
          end
        end
        hdap_pkg::ST_GAP: begin
          st_nxt = hdap_pkg::ST_QSKIP; cnt_nxt = 4'd4;
        end
        default: fail = 1'b1;
      endcase
      if (fail) halt_nxt = hdap_pkg::HALT_ERR;
    end
  end

  // Pack the results of this item in order
  always_comb begin
    n = 2'd0;
    sk = '{default: hdap_pkg::K_CHR};
    sb = '0;
    err = hdap_pkg::ERR_NONE;
    if (halt_r == hdap_pkg::HALT_RUN) begin
      if (fail) begin
        sk[n] = hdap_pkg::K_ERR; err = fail_code; n = n + 2'd1;
      end else begin
        if (e_cr) begin
          sk[n] = hdap_pkg::K_CHR; sb[n] = hdap_pkg::CH_CR; n = n + 2'd1;
        end
        if (e_chr) begin
          sk[n] = hdap_pkg::K_CHR; sb[n] = data_byte; n = n + 2'd1;
        end
        if (e_addr) begin
          sk[n] = hdap_pkg::K_ADDR; sb[n] = data_byte; n = n + 2'd1;
        end
        if (e_ok) begin
          sk[n] = hdap_pkg::K_OK; n = n + 2'd1;
        end
      end
      if (eom && halt_nxt == hdap_pkg::HALT_RUN) begin
        if (pos_nxt != 4'd0) begin
          sk[n] = hdap_pkg::K_ERR; err = hdap_pkg::ERR_TRUNC;
        end else sk[n] = hdap_pkg::K_OK;
        n = n + 2'd1;
      end
    end
  end

  assign push = item_take && (n != 2'd0);

  always_comb begin
    bundle.n = n;
    bundle.kind = sk;
    bundle.data = sb;
    bundle.err = err;
    bundle.idx = pos_r;
    bundle.v6 = is6;
    bundle.rec = rec;
    bundle.ttl = ttl_nxt;
    bundle.status = status_nxt;
    bundle.v4_cnt = 16'(v4_nxt);
    bundle.v6_cnt = 16'(v6_nxt);
  end

  // Max answers register, then parser state; end of message restarts the parser
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxa_r <= hdap_pkg::MAX_ANSWERS_RST;
    end else if (cfg_wr_en) begin
      maxa_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (item_take && eom)) begin
      st_r <= hdap_pkg::ST_LIT; halt_r <= hdap_pkg::HALT_RUN; cnt_r <= 4'd0;
      status_r <= '0; total_r <= '0; ttl_r <= '0; pos_r <= '0; v4_r <= '0; v6_r <= '0;
    end else if (item_take) begin
      st_r <= st_nxt; halt_r <= halt_nxt; cnt_r <= cnt_nxt;
      status_r <= status_nxt; total_r <= total_nxt; ttl_r <= ttl_nxt;
      pos_r <= pos_nxt; v4_r <= v4_nxt; v6_r <= v6_nxt;
    end
  end

endmodule

// ----- design/hdap_queue.sv -----
// Short queue of result bundles between the front and back ends.
module hdap_queue #(
  parameter int DEPTH = hdap_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hdap_pkg::bundle_t push_data,
  input  logic              pop,
  output hdap_pkg::bundle_t head,
  output logic              not_empty,
  output logic              not_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdap_pkg::bundle_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign not_empty = (cnt_r != '0);
  assign not_full  = (cnt_r != CW'(DEPTH));
  assign head      = mem_r[rp_r];

  // Store pushed bundles
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (not_full || pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ----- design/hdap_back.sv -----
// Back end: walks the head bundle, one slot per cycle while out_tready is high.
module hdap_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hdap_pkg::bundle_t head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [111:0]      out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  logic [1:0] sub_r;
  hdap_pkg::kind_t kind;
  logic is_addr, is_err;

  assign kind    = head.kind[sub_r];
  assign is_addr = (kind == hdap_pkg::K_ADDR);
  assign is_err  = (kind == hdap_pkg::K_ERR);

  assign out_tvalid = head_valid;
  assign out_tlast  = (sub_r == head.n - 2'd1);
  assign out_tuser  = kind;
  assign pop        = out_tvalid && out_tready && out_tlast;

  // Pack result fields
  assign out_tdata = {6'd0,
                      is_err ? head.err : hdap_pkg::ERR_NONE,
                      head.v6_cnt, head.v4_cnt, head.status, head.ttl,
                      is_addr ? head.rec : 16'd0,
                      is_addr & head.v6,
                      is_addr ? head.idx : 4'd0,
                      head.data[sub_r]};

  // Step through the slots of the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) sub_r <= 2'd0;
    else if (out_tvalid && out_tready) sub_r <= out_tlast ? 2'd0 : sub_r + 2'd1;
  end

  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> head.n != 2'd0) else $error("empty bundle queued");
  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sub_r < head.n) else $error("slot index past bundle");
  a_sub_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> sub_r == 2'd0) else $error("slot index not cleared");

endmodule

// ----- design/http_dns_answer_parser_unit.sv -----
// Top level of the HTTP DNS answer parser.
// Takes one message byte per cycle (in_tdata, in_tlast on the final byte) and
// produces up to three results for it: reason characters, address bytes with
// their TTL, and a finished or error verdict. The byte parser runs every cycle
// an item is accepted; its results go through a four-entry bundle queue to an
// output stage that sends one result per cycle while out_tready is high, so
// input accepts one item per cycle while the queue has room, and an item with
// three results leaves as three output transfers. No clearing pass after reset.
module http_dns_answer_parser_unit #(
  parameter int COUNT_WIDTH = hdap_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = hdap_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,   // max_answers
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,      // data_byte
  input  logic         in_tlast,      // end_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_byte[7:0] byte_index[11:8] is_ipv6[12] record_index[28:13]
  // ttl_seconds[60:29] status_value[70:61] ipv4_count[86:71]
  // ipv6_count[102:87] error_reason[105:103], zero pad above
  output logic [111:0] out_tdata,
  output logic [1:0]   out_tuser,     // kind
  output logic         out_tlast      // last_of_run
);

  logic take, push, pop, head_valid, not_full;
  hdap_pkg::bundle_t bundle, head;

  assign in_tready = not_full;
  assign take = in_tvalid && in_tready;

  hdap_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .item_take(take), .data_byte(in_tdata), .eom(in_tlast),
    .push, .bundle
  );

  hdap_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .push_data(bundle), .pop,
    .head, .not_empty(head_valid), .not_full
  );

  hdap_back u_back (
    .clk, .rst_n, .head, .head_valid, .pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule
